// File: rtl/emspm_pkg.sv
`default_nettype none
package emspm_pkg;

   localparam int HANDLE_COUNT_DEF = 256;
   localparam int TOTAL_PAGES_DEF  = 1024;
   localparam int FRAME_SLOTS      = 4;

   localparam logic [15:0] FRAME_SEG_RESET = 16'hC000;
   localparam logic [15:0] UNMAP_PAGE      = 16'hFFFF;
   localparam int          SLOT_SHIFT      = 10;

   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_FREE    = 3'd1;
   localparam logic [2:0] OP_MAP     = 3'd2;
   localparam logic [2:0] OP_SAVE    = 3'd3;
   localparam logic [2:0] OP_RESTORE = 3'd4;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_HANDLE   = 3'd1;
   localparam logic [2:0] ST_NO_HANDLES   = 3'd2;
   localparam logic [2:0] ST_FEW_PAGES    = 3'd3;
   localparam logic [2:0] ST_BAD_SLOT     = 3'd4;
   localparam logic [2:0] ST_BAD_PAGE     = 3'd5;
   localparam logic [2:0] ST_RESTORE_FAIL = 3'd6;

   typedef struct packed {
      logic [7:0]  hnd;
      logic [15:0] page;
   } slot_entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_MAP,
      S_SAVE,
      S_RST_RD,
      S_RST_PG,
      S_RST_CHK,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// File: rtl/expanded_memory_page_mapper_top.sv
// Channel   | Ports                         | Contents
// req       | req_tvalid/tready/tdata       | one mapper request
// rsp       | rsp_tvalid/tready/tdata       | status, new handle, free pages
// csr       | csr_valid/ready/data          | frame segment
//
// Query and spare ops go straight to S_RESP; map and free pass through S_MAP or S_FREE; save
// writes each slot in S_SAVE. Restore: per slot a save-area read, a page-count read and a
// check, stopping at the first failing slot. Allocate: the free-handle scan probes handles
// from 1 up to HANDLE_COUNT-1. After reset the save area is swept to zero, HANDLE_COUNT*4
// entries rounded up to a power of two, no requests taken.
// A finished result sits in the output register; the next request is taken meanwhile and
// its result waits in S_RESP, with the input stalled, until the register drains.
`default_nettype none
module expanded_memory_page_mapper_top #(
   parameter int HANDLE_COUNT = emspm_pkg::HANDLE_COUNT_DEF,
   parameter int TOTAL_PAGES  = emspm_pkg::TOTAL_PAGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[2:0] handle[18:3] page_count[34:19] frame_slot[50:35]
   // frame_seg_in[66:51] by_segment[67] lpage[83:68], zero pad
   input  wire logic [87:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0] new_handle[10:3] free_pages[21:11], zero pad
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   localparam int HW  = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
   localparam int SAW = $clog2(HANDLE_COUNT * emspm_pkg::FRAME_SLOTS);
   localparam int PW  = $clog2(TOTAL_PAGES + 1);
   localparam int SW  = $clog2(emspm_pkg::FRAME_SLOTS);

   emspm_pkg::state_type state_ff, state_in;

   logic [2:0]   op_ff, op_in;
   logic [15:0]  hnd_ff, hnd_in;
   logic [15:0]  cnt_ff, cnt_in;
   logic [15:0]  page_ff, page_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic         slot_ok_ff, slot_ok_in;
   logic [HW:0]  scan_ff, scan_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SAW-1:0] clr_ff, clr_in;
   logic [HANDLE_COUNT-1:0] valid_ff, valid_in;
   logic [PW-1:0] inuse_ff, inuse_in;
   emspm_pkg::slot_entry_type slots_ff [emspm_pkg::FRAME_SLOTS];
   emspm_pkg::slot_entry_type slots_in [emspm_pkg::FRAME_SLOTS];
   logic [2:0]   res_status_ff, res_status_in;
   logic [7:0]   res_given_ff, res_given_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [21:0]  rsp_data_ff, rsp_data_in;
   logic [15:0]  fseg_ff;

   // page-count memory
   logic [15:0]  pg_mem [HANDLE_COUNT];
   logic [15:0]  pg_rd_ff;
   logic [HW-1:0] pg_raddr, pg_waddr;
   logic         pg_we;
   logic [15:0]  pg_wdata;

   // context save area
   emspm_pkg::slot_entry_type sv_mem [HANDLE_COUNT * emspm_pkg::FRAME_SLOTS];
   emspm_pkg::slot_entry_type sv_rd_ff, sv_wdata;
   logic [SAW-1:0] sv_raddr, sv_waddr;
   logic         sv_we;

   logic         req_acc, rsp_free;
   logic [15:0]  seg_diff, slot_sel;
   logic [PW-1:0] free_now;
   logic         map_unmap, map_hval, map_pbad;
   logic         rst_unmap, rst_hval, rst_pbad, rst_fail;
   logic         scan_end, scan_free, few;
   logic         hnd_ok;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == emspm_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign free_now   = PW'(TOTAL_PAGES) - inuse_ff;

   assign seg_diff = req_tdata[66:51] - fseg_ff;
   assign slot_sel = req_tdata[67] ? (seg_diff >> emspm_pkg::SLOT_SHIFT) : req_tdata[50:35];

   always_comb begin
      hnd_ok    = hnd_ff < 16'(HANDLE_COUNT);
      map_unmap = (hnd_ff == 16'd0) || (page_ff == emspm_pkg::UNMAP_PAGE);
      map_hval  = hnd_ok && valid_ff[hnd_ff[HW-1:0]];
      map_pbad  = page_ff >= pg_rd_ff;
      rst_unmap = (sv_rd_ff.hnd == 8'd0) || (sv_rd_ff.page == emspm_pkg::UNMAP_PAGE);
      rst_hval  = (16'(sv_rd_ff.hnd) < 16'(HANDLE_COUNT)) && valid_ff[sv_rd_ff.hnd[HW-1:0]];
      rst_pbad  = sv_rd_ff.page >= pg_rd_ff;
      rst_fail  = !rst_unmap && (!rst_hval || rst_pbad);
      scan_end  = scan_ff >= (HW+1)'(HANDLE_COUNT);
      scan_free = !valid_ff[scan_ff[HW-1:0]];
      few       = {1'b0, cnt_ff} > 17'(free_now);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         emspm_pkg::S_CLEAR: begin
            if (clr_ff == {SAW{1'b1}}) state_in = emspm_pkg::S_IDLE;
         end
         emspm_pkg::S_IDLE: begin
            if (req_acc) begin
               case (req_tdata[2:0])
                  emspm_pkg::OP_ALLOC: state_in = emspm_pkg::S_SCAN;
                  emspm_pkg::OP_FREE: state_in = emspm_pkg::S_FREE;
                  emspm_pkg::OP_MAP: state_in = emspm_pkg::S_MAP;
                  emspm_pkg::OP_SAVE: state_in = emspm_pkg::S_SAVE;
                  emspm_pkg::OP_RESTORE: state_in = emspm_pkg::S_RST_RD;
                  default: state_in = emspm_pkg::S_RESP;
               endcase
            end
         end
         emspm_pkg::S_SCAN: begin
            if (scan_end || scan_free) state_in = emspm_pkg::S_RESP;
         end
         emspm_pkg::S_FREE, emspm_pkg::S_MAP: state_in = emspm_pkg::S_RESP;
         emspm_pkg::S_SAVE: begin
            if (!hnd_ok || idx_ff == {SW{1'b1}}) state_in = emspm_pkg::S_RESP;
         end
         emspm_pkg::S_RST_RD: begin
            state_in = hnd_ok ? emspm_pkg::S_RST_PG : emspm_pkg::S_RESP;
         end
         emspm_pkg::S_RST_PG: state_in = emspm_pkg::S_RST_CHK;
         emspm_pkg::S_RST_CHK: begin
            if (rst_fail || idx_ff == {SW{1'b1}}) state_in = emspm_pkg::S_RESP;
            else state_in = emspm_pkg::S_RST_RD;
         end
         emspm_pkg::S_RESP: begin
            if (rsp_free) state_in = emspm_pkg::S_IDLE;
         end
         default: state_in = emspm_pkg::S_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      op_in = op_ff;
      hnd_in = hnd_ff;
      cnt_in = cnt_ff;
      page_in = page_ff;
      slot_in = slot_ff;
      slot_ok_in = slot_ok_ff;
      scan_in = scan_ff;
      idx_in = idx_ff;
      clr_in = clr_ff;
      valid_in = valid_ff;
      inuse_in = inuse_ff;
      slots_in = slots_ff;
      res_status_in = res_status_ff;
      res_given_in = res_given_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      pg_raddr = hnd_ff[HW-1:0];
      pg_we = 1'b0;
      pg_waddr = scan_ff[HW-1:0];
      pg_wdata = cnt_ff;
      sv_raddr = {hnd_ff[HW-1:0], idx_ff};
      sv_we = 1'b0;
      sv_waddr = {hnd_ff[HW-1:0], idx_ff};
      sv_wdata = slots_ff[idx_ff];
      unique case (state_ff)
         emspm_pkg::S_CLEAR: begin
            sv_we = 1'b1;
            sv_waddr = clr_ff;
            sv_wdata = '0;
            clr_in = clr_ff + 1'b1;
         end
         emspm_pkg::S_IDLE: begin
            pg_raddr = req_tdata[HW+2:3];
            if (req_acc) begin
               op_in = req_tdata[2:0];
               hnd_in = req_tdata[18:3];
               cnt_in = req_tdata[34:19];
               page_in = req_tdata[83:68];
               slot_in = slot_sel[SW-1:0];
               slot_ok_in = slot_sel < 16'(emspm_pkg::FRAME_SLOTS);
               scan_in = (HW+1)'(1);
               idx_in = '0;
               res_status_in = emspm_pkg::ST_OK;
               res_given_in = '0;
            end
         end
         emspm_pkg::S_SCAN: begin
            pg_waddr = scan_ff[HW-1:0];
            if (scan_end) begin
               res_status_in = emspm_pkg::ST_NO_HANDLES;
            end else if (scan_free) begin
               if (few) begin
                  res_status_in = emspm_pkg::ST_FEW_PAGES;
               end else begin
                  valid_in[scan_ff[HW-1:0]] = 1'b1;
                  pg_we = 1'b1;
                  inuse_in = inuse_ff + cnt_ff[PW-1:0];
                  res_given_in = 8'(scan_ff);
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         emspm_pkg::S_FREE: begin
            if (!hnd_ok) begin
               res_status_in = emspm_pkg::ST_BAD_HANDLE;
            end else if (valid_ff[hnd_ff[HW-1:0]]) begin
               inuse_in = inuse_ff - pg_rd_ff[PW-1:0];
               valid_in[hnd_ff[HW-1:0]] = 1'b0;
               for (int i = 0; i < emspm_pkg::FRAME_SLOTS; i++) begin
                  if (16'(slots_ff[i].hnd) == hnd_ff) slots_in[i] = '0;
               end
            end
         end
         emspm_pkg::S_MAP: begin
            if (!slot_ok_ff) begin
               res_status_in = emspm_pkg::ST_BAD_SLOT;
            end else if (map_unmap) begin
               slots_in[slot_ff] = '0;
            end else if (!map_hval) begin
               res_status_in = emspm_pkg::ST_BAD_HANDLE;
            end else if (map_pbad) begin
               res_status_in = emspm_pkg::ST_BAD_PAGE;
            end else begin
               slots_in[slot_ff].hnd = hnd_ff[7:0];
               slots_in[slot_ff].page = page_ff;
            end
         end
         emspm_pkg::S_SAVE: begin
            if (!hnd_ok) begin
               res_status_in = emspm_pkg::ST_BAD_HANDLE;
            end else begin
               sv_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         emspm_pkg::S_RST_RD: begin
            if (!hnd_ok) res_status_in = emspm_pkg::ST_BAD_HANDLE;
         end
         emspm_pkg::S_RST_PG: begin
            pg_raddr = sv_rd_ff.hnd[HW-1:0];
         end
         emspm_pkg::S_RST_CHK: begin
            if (rst_fail) begin
               res_status_in = emspm_pkg::ST_RESTORE_FAIL;
            end else begin
               slots_in[idx_ff] = rst_unmap ? '0 : sv_rd_ff;
               idx_in = idx_ff + 1'b1;
            end
         end
         emspm_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {11'(free_now), res_given_ff, res_status_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emspm_pkg::S_CLEAR;
         clr_ff <= '0;
         valid_ff <= '0;
         inuse_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fseg_ff <= emspm_pkg::FRAME_SEG_RESET;
         for (int i = 0; i < emspm_pkg::FRAME_SLOTS; i++) slots_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         valid_ff <= valid_in;
         inuse_ff <= inuse_in;
         rsp_valid_ff <= rsp_valid_in;
         slots_ff <= slots_in;
         if (csr_valid && csr_ready) fseg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      hnd_ff <= hnd_in;
      cnt_ff <= cnt_in;
      page_ff <= page_in;
      slot_ff <= slot_in;
      slot_ok_ff <= slot_ok_in;
      scan_ff <= scan_in;
      idx_ff <= idx_in;
      res_status_ff <= res_status_in;
      res_given_ff <= res_given_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (pg_we) pg_mem[pg_waddr] <= pg_wdata;
      pg_rd_ff <= pg_mem[pg_raddr];
   end

   always_ff @(posedge clock) begin
      if (sv_we) sv_mem[sv_waddr] <= sv_wdata;
      sv_rd_ff <= sv_mem[sv_raddr];
   end

   a_inuse_bound: assert property (@(posedge clock) disable iff (reset)
      inuse_ff <= PW'(TOTAL_PAGES))
      else $error("pages in use exceed total");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == emspm_pkg::S_CLEAR |-> !req_tready)
      else $error("request taken during save-area sweep");

   a_slot0_valid: assert property (@(posedge clock) disable iff (reset)
      slots_ff[0].hnd != 8'd0 |-> valid_ff[slots_ff[0].hnd[HW-1:0]])
      else $error("slot 0 maps a freed handle");

   a_op_latched: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> op_ff == $past(req_tdata[2:0]))
      else $error("request op not captured");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int HANDLES   = emspm_pkg::HANDLE_COUNT_DEF;
   localparam int PAGES     = emspm_pkg::TOTAL_PAGES_DEF;
   localparam int CYCLE_CAP = 2_000_000;
   localparam logic [2:0] OP_QUERY  = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0]  status;
      logic [7:0]  new_handle;
      logic [10:0] free_pages;
   } mapper_result_type;

   class mapper_scoreboard;
      logic [15:0]    frame_seg;
      bit             hvalid[HANDLES];
      logic [15:0]    hpages[HANDLES];
      int unsigned    in_use;
      emspm_pkg::slot_entry_type slots[emspm_pkg::FRAME_SLOTS];
      emspm_pkg::slot_entry_type saved[HANDLES * emspm_pkg::FRAME_SLOTS];
      mapper_result_type result_q[$];
      int             errors;
      int             requests;
      int             responses;

      function new();
         frame_seg = emspm_pkg::FRAME_SEG_RESET;
         foreach (hvalid[i]) hvalid[i] = 0;
         foreach (hpages[i]) hpages[i] = '0;
         foreach (slots[i]) slots[i] = '0;
         foreach (saved[i]) saved[i] = '0;
         in_use = 0;
         errors = 0;
         requests = 0;
         responses = 0;
      endfunction

      function bit handle_free_left();
         for (int h = 1; h < HANDLES; h++)
            if (!hvalid[h]) return 1;
         return 0;
      endfunction

      function logic [2:0] place_page(int unsigned slot, logic [15:0] hnd, logic [15:0] page);
         if (slot >= emspm_pkg::FRAME_SLOTS) return emspm_pkg::ST_BAD_SLOT;
         if (hnd != 0 && page != emspm_pkg::UNMAP_PAGE) begin
            if (hnd >= HANDLES || !hvalid[hnd]) return emspm_pkg::ST_BAD_HANDLE;
            if (page >= hpages[hnd]) return emspm_pkg::ST_BAD_PAGE;
            slots[slot].hnd  = hnd[7:0];
            slots[slot].page = page;
         end else begin
            slots[slot] = '0;
         end
         return emspm_pkg::ST_OK;
      endfunction

      function void note_request(logic [87:0] d);
         logic [2:0]     op;
         logic [15:0]    hnd, cnt, fslot, fseg, page;
         logic           byseg;
         logic [15:0]    diff;
         int unsigned    h, slot;
         mapper_result_type res;
         op    = d[2:0];
         hnd   = d[18:3];
         cnt   = d[34:19];
         fslot = d[50:35];
         fseg  = d[66:51];
         byseg = d[67];
         page  = d[83:68];
         res.status = emspm_pkg::ST_OK;
         res.new_handle = '0;
         case (op)
            emspm_pkg::OP_ALLOC: begin
               h = 1;
               while (h < HANDLES && hvalid[h]) h++;
               if (h >= HANDLES) res.status = emspm_pkg::ST_NO_HANDLES;
               else if (cnt > PAGES - in_use) res.status = emspm_pkg::ST_FEW_PAGES;
               else begin
                  hvalid[h] = 1;
                  hpages[h] = cnt;
                  in_use += cnt;
                  res.new_handle = h[7:0];
               end
            end
            emspm_pkg::OP_FREE: begin
               if (hnd >= HANDLES) res.status = emspm_pkg::ST_BAD_HANDLE;
               else if (hvalid[hnd]) begin
                  in_use -= hpages[hnd];
                  foreach (slots[i])
                     if (slots[i].hnd == hnd[7:0]) slots[i] = '0;
                  hvalid[hnd] = 0;
               end
            end
            emspm_pkg::OP_MAP: begin
               diff = fseg - frame_seg;
               slot = byseg ? 32'(diff >> emspm_pkg::SLOT_SHIFT) : 32'(fslot);
               res.status = place_page(slot, hnd, page);
            end
            emspm_pkg::OP_SAVE: begin
               if (hnd >= HANDLES) res.status = emspm_pkg::ST_BAD_HANDLE;
               else foreach (slots[i]) saved[hnd * emspm_pkg::FRAME_SLOTS + i] = slots[i];
            end
            emspm_pkg::OP_RESTORE: begin
               if (hnd >= HANDLES) res.status = emspm_pkg::ST_BAD_HANDLE;
               else begin
                  // stops at the first slot that fails, earlier slots keep the new mapping
                  for (int i = 0; i < emspm_pkg::FRAME_SLOTS; i++) begin
                     if (place_page(i, {8'd0, saved[hnd * emspm_pkg::FRAME_SLOTS + i].hnd},
                                    saved[hnd * emspm_pkg::FRAME_SLOTS + i].page)
                         != emspm_pkg::ST_OK) begin
                        res.status = emspm_pkg::ST_RESTORE_FAIL;
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         res.free_pages = 11'(PAGES - in_use);
         result_q.push_back(res);
         requests++;
      endfunction

      function void check_response(logic [23:0] r);
         mapper_result_type exp_res;
         responses++;
         if (result_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, r);
            errors++;
            return;
         end
         exp_res = result_q.pop_front();
         if (r[2:0] !== exp_res.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_res.status, r[2:0]);
            errors++;
         end
         if (r[10:3] !== exp_res.new_handle) begin
            $display("%0t: new_handle exp %0d got %0d", $time, exp_res.new_handle, r[10:3]);
            errors++;
         end
         if (r[21:11] !== exp_res.free_pages) begin
            $display("%0t: free_pages exp %0d got %0d", $time, exp_res.free_pages, r[21:11]);
            errors++;
         end
         if (r[23:22] !== 2'b00) begin
            $display("%0t: pad exp 0 got %b", $time, r[23:22]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   mapper_scoreboard sb = new();
   int rsp_hold = 0;
   int cycles = 0;
   int csr_writes = 0;

   expanded_memory_page_mapper_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // response side: random stalls, plus a long hold-off when asked for
   initial begin : rsp_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 99) < 60) begin
            rsp_tready <= 1;
         end else begin
            stall = gap_len();
            rsp_tready <= 0;
         end
      end
   end

   function automatic logic [87:0] pack_req(logic [2:0] op, logic [15:0] hnd, logic [15:0] cnt,
                                            logic [15:0] fslot, logic [15:0] fseg,
                                            logic byseg, logic [15:0] page);
      return {4'b0000, page, byseg, fseg, fslot, cnt, hnd, op};
   endfunction

   task automatic send_req(logic [87:0] d, int gap);
      req_tvalid <= 1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.result_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_frame_seg(logic [15:0] v);
      drain();
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.frame_seg = v;
      csr_writes++;
   endtask

   function automatic logic [15:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 16'($urandom_range(1, 12));
      if (r < 85) return 16'($urandom_range(0, HANDLES - 1));
      if (r < 95) return 16'($urandom_range(HANDLES, 65535));
      return (r < 97) ? 16'hFFFF : 16'h0000;
   endfunction

   function automatic logic [15:0] pick_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 16'($urandom_range(0, 15));
      if (r < 90) return emspm_pkg::UNMAP_PAGE;
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [87:0] random_req();
      int          r;
      logic [2:0]  op;
      logic [15:0] cnt, fslot, fseg;
      r = $urandom_range(0, 99);
      if (r < 25) op = emspm_pkg::OP_ALLOC;
      else if (r < 40) op = emspm_pkg::OP_FREE;
      else if (r < 70) op = emspm_pkg::OP_MAP;
      else if (r < 80) op = emspm_pkg::OP_SAVE;
      else if (r < 92) op = emspm_pkg::OP_RESTORE;
      else if (r < 96) op = OP_QUERY;
      else op = (r < 98) ? OP_SPARE6 : OP_SPARE7;
      r = $urandom_range(0, 99);
      if (r < 80) cnt = 16'($urandom_range(0, 20));
      else if (r < 95) cnt = 16'($urandom_range(0, 1100));
      else cnt = 16'($urandom_range(0, 65535));
      fslot = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3))
                                         : 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) < 8)
         fseg = sb.frame_seg + 16'($urandom_range(0, 3) << emspm_pkg::SLOT_SHIFT)
                + 16'($urandom_range(0, 1023));
      else
         fseg = 16'($urandom_range(0, 65535));
      return pack_req(op, pick_handle(), cnt, fslot, fseg, 1'($urandom_range(0, 1)),
                      pick_page());
   endfunction

   task automatic random_run(int n);
      repeat (n) send_req(random_req(), gap_len());
   endtask

   initial begin : stimulus
      int drain_wait;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed, frame segment at its reset value
      send_req(pack_req(OP_QUERY, 0, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(OP_SPARE6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF), 0);
      send_req(pack_req(OP_SPARE7, 0, 0, 0, 0, 0, 0), 1);
      send_req(pack_req(emspm_pkg::OP_ALLOC, 0, 2000, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_ALLOC, 0, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_ALLOC, 0, 1024, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_FREE, 2, 0, 0, 0, 0, 0), 2);
      send_req(pack_req(emspm_pkg::OP_ALLOC, 0, 10, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 2, 0, 0, 0, 0, 9), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 2, 0, 1, 0, 0, 10), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 2, 0, 5, 0, 0, 1), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 2, 0, 16'hFFFF, 0, 0, 1), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 2, 0, 0, 16'hC403, 1, 0), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 2, 0, 0, 16'hBFFF, 1, 0), 3);
      send_req(pack_req(emspm_pkg::OP_MAP, 300, 0, 2, 0, 0, 1), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 7, 0, 2, 0, 0, 1), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 16'hFFFF, 0, 3, 0, 0, 16'hFFFF), 0);
      send_req(pack_req(emspm_pkg::OP_SAVE, 2, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_SAVE, 256, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_FREE, 0, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_FREE, 16'hFFFF, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_MAP, 1, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_RESTORE, 2, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_FREE, 2, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_RESTORE, 2, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_RESTORE, 16'hFFFF, 0, 0, 0, 0, 0), 0);
      send_req(pack_req(emspm_pkg::OP_RESTORE, 9, 0, 0, 0, 0, 0), 0);

      // long receiver hold-off while requests keep coming, then sender waits it out
      rsp_hold = 400;
      repeat (12) send_req(random_req(), 0);
      drain();

      write_frame_seg(16'h0000);
      random_run(60);
      write_frame_seg(16'hFFFF);
      random_run(60);

      // fill the handle table, then run out of handles
      while (sb.handle_free_left())
         send_req(pack_req(emspm_pkg::OP_ALLOC, 0, 16'($urandom_range(0, 3)), 0, 0, 0, 0),
                  gap_len());
      repeat (2) send_req(pack_req(emspm_pkg::OP_ALLOC, 0, 0, 0, 0, 0, 0), 0);
      write_frame_seg(16'($urandom_range(0, 65535)));
      random_run(70);
      drain();

      drain_wait = 0;
      while (sb.result_q.size() != 0 && drain_wait < 10000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (300) @(posedge clock);
      $display("%0d requests, %0d responses, %0d frame segment writes",
               sb.requests, sb.responses, csr_writes);
      $display("covered allocate, free, map, save, restore, query and table exhaustion");
      if (sb.errors == 0 && sb.result_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", sb.errors, sb.result_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/emspm_pkg.sv
rtl/expanded_memory_page_mapper_top.sv
tb/sv/tb.sv
